### design/bitmap_range_set_clear_find_zero_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap allocator
// Shared property forms used by the bitmap allocator top level.
// ----------------------------------------------------------------------------
`ifndef BITMAP_RANGE_SET_CLEAR_FIND_ZERO_ASSERT_SVH
`define BITMAP_RANGE_SET_CLEAR_FIND_ZERO_ASSERT_SVH

// Condition c holds in the same cycle as a.
`define BMRS_ASSERT_SAME(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("bitmap allocator: same-cycle check failed");

// Condition c holds in the cycle after a.
`define BMRS_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("bitmap allocator: next-cycle check failed");

`endif

### design/bmrs_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap allocator package
// Default sizes, request codes and helper functions of the bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bmrs_pkg;

    // Default store geometry.
    localparam int WORD_BITS_DEF = 32;
    localparam int NUM_WORDS_DEF = 32;

    // Request field widths.
    localparam int CMD_W   = 2;
    localparam int START_W = 10;
    localparam int COUNT_W = 11;
    localparam int LIMIT_W = 11;
    localparam int INDEX_W = 10;

    typedef logic [CMD_W-1:0] t_cmd;

    // Request codes.
    localparam t_cmd CMD_SET   = 2'd0;
    localparam t_cmd CMD_CLEAR = 2'd1;
    localparam t_cmd CMD_FIND  = 2'd2;

    // Address width of a store of the given depth, at least one bit.
    function automatic int f_addr_bits(input int depth);
        f_addr_bits = (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

`default_nettype wire

### design/bmrs_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bmrs_ram #(
    parameter int WIDTH = bmrs_pkg::WORD_BITS_DEF,
    parameter int DEPTH = bmrs_pkg::NUM_WORDS_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [bmrs_pkg::f_addr_bits(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [bmrs_pkg::f_addr_bits(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);
    import bmrs_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### design/bitmap_range_set_clear_find_zero.sv
// ----------------------------------------------------------------------------
// Bitmap allocator with range set, range clear and find first zero
// A bitmap allocator holding NUM_WORDS words of WORD_BITS bits, kept in a RAM
// with one write and one registered read port. After reset a clearing pass
// writes zero to every word, during which no request is taken. A set or
// clear request walks the words from word zero up to the word that holds the
// last bit of the run (or the last word), each word read, then modified and
// written back. A find request reads each word, isolates the lowest zero
// with one add and encodes it, and stops at the first word holding a zero or
// at the search limit. Any other request code walks no word and gets a
// response with no bit found. One request is worked on at a time; its
// response waits in an output register, and a stalled response holds the
// sequencer until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitmap_range_set_clear_find_zero_assert.svh"

module bitmap_range_set_clear_find_zero #(
    parameter int WORD_BITS = bmrs_pkg::WORD_BITS_DEF,
    parameter int NUM_WORDS = bmrs_pkg::NUM_WORDS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [bmrs_pkg::CMD_W-1:0]   i_command,
    input  wire logic [bmrs_pkg::START_W-1:0] i_range_start,
    input  wire logic [bmrs_pkg::COUNT_W-1:0] i_range_count,
    input  wire logic [bmrs_pkg::LIMIT_W-1:0] i_search_limit,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic                              o_found,
    output logic      [bmrs_pkg::INDEX_W-1:0] o_bit_index
);
    import bmrs_pkg::*;

    // Geometry.
    localparam int TOTAL_BITS = WORD_BITS * NUM_WORDS;
    localparam int AW = f_addr_bits(NUM_WORDS);
    localparam int END_W = START_W + 2;
    localparam int PW = ($clog2(TOTAL_BITS + 1) > END_W) ? $clog2(TOTAL_BITS + 1) : END_W;
    localparam int CW = $clog2(WORD_BITS + 1);
    localparam int BW = $clog2(WORD_BITS);
    localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);
    localparam logic [PW-1:0] WB_P = PW'(WORD_BITS);
    localparam logic [CW-1:0] WB_C = CW'(WORD_BITS);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CLR  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_OP   = 3'd3;
    localparam logic [2:0] S_ENC  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]           r_state, n_state;
    logic [AW-1:0]        r_word, n_word;
    logic [PW-1:0]        r_base, n_base;
    t_cmd                 r_cmd, n_cmd;
    logic [START_W-1:0]   r_start, n_start;
    logic [END_W-1:0]     r_end, n_end;
    logic [LIMIT_W-1:0]   r_limit, n_limit;
    logic [WORD_BITS-1:0] r_iso, n_iso;
    logic                 r_res_found, n_res_found;
    logic [INDEX_W-1:0]   r_res_idx, n_res_idx;
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_found, n_out_found;
    logic [INDEX_W-1:0]   r_out_idx, n_out_idx;

    logic                 ram_we;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;

    logic                 in_accept;
    logic                 out_free;
    logic [PW-1:0]        bound;
    logic [PW:0]          diff_lo, diff_hi;
    logic [CW-1:0]        lo, hi;
    logic [WORD_BITS-1:0] mask;
    logic [BW-1:0]        zero_bit;
    logic [PW-1:0]        zero_idx;
    logic                 zero_hit;

    // Word store.
    bmrs_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_word),
        .i_wdata (ram_wdata),
        .i_raddr (r_word),
        .o_rdata (ram_rdata)
    );

    // Handshakes.
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Upper bound of the walk for the current request.
    assign bound = (r_cmd == CMD_FIND) ? PW'(r_limit) : PW'(r_end);

    // Run bounds relative to the current word, clamped to the word.
    always_comb begin
        diff_lo = {1'b0, PW'(r_start)} - {1'b0, r_base};
        diff_hi = {1'b0, PW'(r_end)} - {1'b0, r_base};
        if (diff_lo[PW]) begin
            lo = '0;
        end else if (diff_lo[PW-1:0] >= WB_P) begin
            lo = WB_C;
        end else begin
            lo = diff_lo[CW-1:0];
        end
        if (diff_hi[PW]) begin
            hi = '0;
        end else if (diff_hi[PW-1:0] >= WB_P) begin
            hi = WB_C;
        end else begin
            hi = diff_hi[CW-1:0];
        end
    end

    // Bits of the current word that lie inside the run.
    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            mask[j] = (CW'(j) >= lo) && (CW'(j) < hi);
        end
    end

    // Modified word for a set or clear.
    assign ram_wdata = (r_state == S_CLR) ? '0 :
                       (r_cmd == CMD_SET) ? (ram_rdata | mask) : (ram_rdata & ~mask);
    assign ram_we = (r_state == S_CLR) ||
                    ((r_state == S_OP) && (r_cmd != CMD_FIND));

    // Binary position of the isolated lowest zero.
    always_comb begin
        zero_bit = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            if (r_iso[j]) begin
                zero_bit = zero_bit | BW'(j);
            end
        end
    end

    assign zero_hit = (r_iso != '0);
    assign zero_idx = r_base + PW'(zero_bit);

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_word      = r_word;
        n_base      = r_base;
        n_cmd       = r_cmd;
        n_start     = r_start;
        n_end       = r_end;
        n_limit     = r_limit;
        n_iso       = r_iso;
        n_res_found = r_res_found;
        n_res_idx   = r_res_idx;
        n_out_valid = r_out_valid;
        n_out_found = r_out_found;
        n_out_idx   = r_out_idx;

        // The response is taken downstream.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_cmd       = i_command;
                    n_start     = i_range_start;
                    n_end       = END_W'(i_range_start) + END_W'(i_range_count);
                    n_limit     = i_search_limit;
                    n_word      = '0;
                    n_base      = '0;
                    n_res_found = 1'b0;
                    n_res_idx   = '0;
                    if (i_command inside {CMD_SET, CMD_CLEAR, CMD_FIND}) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CLR: begin
                if (r_word == LAST_WORD) begin
                    n_word  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_word = r_word + 1'b1;
                end
            end
            S_RD: begin
                // Stop once the walk has passed the run or the search limit.
                if (r_base >= bound) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_OP;
                end
            end
            S_OP: begin
                if (r_cmd == CMD_FIND) begin
                    // Isolate the lowest zero bit; all ones gives zero.
                    n_iso   = ~ram_rdata & (ram_rdata + 1'b1);
                    n_state = S_ENC;
                end else if (r_word == LAST_WORD) begin
                    n_state = S_DONE;
                end else begin
                    n_word  = r_word + 1'b1;
                    n_base  = r_base + WB_P;
                    n_state = S_RD;
                end
            end
            S_ENC: begin
                if (zero_hit) begin
                    n_res_found = (zero_idx < PW'(r_limit));
                    n_res_idx   = (zero_idx < PW'(r_limit)) ? zero_idx[INDEX_W-1:0] : '0;
                    n_state     = S_DONE;
                end else if (r_word == LAST_WORD) begin
                    n_state = S_DONE;
                end else begin
                    n_word  = r_word + 1'b1;
                    n_base  = r_base + WB_P;
                    n_state = S_RD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_res_found;
                    n_out_idx   = r_res_idx;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_word      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_word      <= n_word;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_base      <= n_base;
        r_cmd       <= n_cmd;
        r_start     <= n_start;
        r_end       <= n_end;
        r_limit     <= n_limit;
        r_iso       <= n_iso;
        r_res_found <= n_res_found;
        r_res_idx   <= n_res_idx;
        r_out_found <= n_out_found;
        r_out_idx   <= n_out_idx;
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out_found;
    assign o_bit_index = r_out_idx;

    // The store is written only during the clearing pass or a set or clear walk.
    `BMRS_ASSERT_SAME(a_no_idle_write, i_clk, i_rst_n, (r_state == S_IDLE), !ram_we)
    // No request is taken while the store is being cleared.
    `BMRS_ASSERT_SAME(a_no_accept_in_clear, i_clk, i_rst_n, (r_state == S_CLR), !in_accept)
    // A found response that is loaded always names a bit below the search limit.
    `BMRS_ASSERT_NEXT(a_found_below_limit, i_clk, i_rst_n,
        (r_state == S_DONE && out_free && r_res_found),
        (o_out_valid && ({1'b0, o_bit_index} < $past(r_limit))))

endmodule

`default_nettype wire
